// ===== hw/rtl/bbnr_pkg.sv =====
// ----------------------------------------------------------------------------
// bbnr_pkg
// Shared types and constants of the 3x3 box blur with noise residual.
// ----------------------------------------------------------------------------
package bbnr_pkg;

   localparam int DEF_MAX_WIDTH   = 2048;
   localparam int DEF_MAX_HEIGHT  = 4096;

   localparam int PIX_BITS        = 8;
   localparam int SUM_BITS        = 12;   // nine 8-bit pixels
   localparam int WIDTH_REG_BITS  = 12;
   localparam int HEIGHT_REG_BITS = 13;
   localparam int MIN_DIM         = 3;
   localparam int WIDTH_RESET     = 512;
   localparam int HEIGHT_RESET    = 512;

   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 32;

   // floor(sum / 9) == (sum * MEAN_RECIP) >> RECIP_SHIFT for sum <= 2295
   localparam int RECIP_BITS      = 13;
   localparam int RECIP_SHIFT     = 16;
   localparam logic [RECIP_BITS-1:0] MEAN_RECIP = 13'd7282;
   localparam int PROD_BITS       = SUM_BITS + RECIP_BITS;

   localparam logic signed [PIX_BITS:0] RESID_LIMIT  = 9'sd127;
   localparam logic [PIX_BITS-1:0]      RESID_OFFSET = 8'd128;

   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_FLUSH = 1'b1
   } kind_type;

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_idx_type;

   // Item held between the counter stage and the window stage
   typedef struct packed {
      logic                final_item;  // frame end, emits held pixel
      logic                drain;       // past the last row, no buffer write
      logic                emit;        // position gives a result
      logic                interior;    // full 3x3 neighborhood available
      logic [PIX_BITS-1:0] pixel;
   } slot_ctl_type;

   // Window stage result handed to the output stage
   typedef struct packed {
      logic [SUM_BITS-1:0] sum;
      logic [PIX_BITS-1:0] orig;
      logic                interior;
      logic                last;
   } win_res_type;

endpackage

// ===== hw/rtl/box_blur_noise_residual.sv =====
// ----------------------------------------------------------------------------
// box_blur_noise_residual
// Streaming 3x3 box mean with noise residual over raster grey pixels.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle unless rsp_tready stalls the pipe; the line buffer is read and written
//   once per pixel, through separate ports of one memory.
// Pipeline: an accepted transaction passes the counter slot, the window result register and the
//   output register ahead of rsp_tvalid; pixel results trail the input by W+1 transactions.
// Reset: clears position counters, window and pipeline valids; the size
//   registers return to 512. The line buffer is not cleared.
module box_blur_noise_residual import bbnr_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                     clock,
   input  logic                     reset,
   // input stream
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [PIX_BITS-1:0]      req_tdata,   // [7:0] pixel_in
   input  logic                     req_tuser,   // [0] kind
   // result stream
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [2*PIX_BITS-1:0]    rsp_tdata,   // [7:0] blurred_pixel, [15:8] noise_pixel
   output logic                     rsp_tlast,   // frame_last
   // configuration
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int CB = $clog2(MAX_WIDTH);
   localparam int WB = $clog2(MAX_WIDTH + 1);
   localparam int HB = $clog2(MAX_HEIGHT + 1);

   logic [WB-1:0]         img_width;
   logic [HB-1:0]         img_height;
   logic                  a_adv, b_free, b_valid, out_ready;
   slot_ctl_type          a_ctl;
   logic [CB-1:0]         a_col, rd_addr, wr_addr;
   logic                  rd_en, wr_en;
   logic [2*PIX_BITS-1:0] rd_data, wr_data;
   win_res_type           b_res;

   bbnr_csr #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .img_width   (img_width),
      .img_height  (img_height)
   );

   bbnr_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .img_width  (img_width),
      .img_height (img_height),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .b_free     (b_free),
      .a_adv      (a_adv),
      .a_ctl      (a_ctl),
      .a_col      (a_col),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr)
   );

   bbnr_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bbnr_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
      .clock     (clock),
      .reset     (reset),
      .a_adv     (a_adv),
      .a_ctl     (a_ctl),
      .a_col     (a_col),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .out_ready (out_ready),
      .b_free    (b_free),
      .b_valid   (b_valid),
      .b_res     (b_res)
   );

   bbnr_out u_out (
      .clock      (clock),
      .reset      (reset),
      .b_valid    (b_valid),
      .b_res      (b_res),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hw/rtl/bbnr_csr.sv =====
// ----------------------------------------------------------------------------
// bbnr_csr
// Image size registers with APB-style access and clamped copies for the core.
// ----------------------------------------------------------------------------
module bbnr_csr import bbnr_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   localparam int WB = $clog2(MAX_WIDTH + 1),
   localparam int HB = $clog2(MAX_HEIGHT + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output logic [WB-1:0]            img_width,
   output logic [HB-1:0]            img_height
);

   localparam int CWW = (WB > WIDTH_REG_BITS) ? WB : WIDTH_REG_BITS;
   localparam int CWH = (HB > HEIGHT_REG_BITS) ? HB : HEIGHT_REG_BITS;

   logic [WIDTH_REG_BITS-1:0]  width_ff,  width_in;
   logic [HEIGHT_REG_BITS-1:0] height_ff, height_in;
   logic                       wr_en;
   reg_idx_type                idx;
   logic [CWW-1:0]             width_ext;
   logic [CWH-1:0]             height_ext;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx        = reg_idx_type'(csr_paddr[2]);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         unique case (idx)
            REG_IMAGE_WIDTH:  width_in  = csr_pwdata[WIDTH_REG_BITS-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_pwdata[HEIGHT_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_REG_BITS'(WIDTH_RESET);
         height_ff <= HEIGHT_REG_BITS'(HEIGHT_RESET);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_BITS'(width_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_BITS'(height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Clamp to the supported frame size
   assign width_ext  = CWW'(width_ff);
   assign height_ext = CWH'(height_ff);

   always_comb begin
      priority if (width_ext < CWW'(MIN_DIM))        img_width = WB'(MIN_DIM);
      else if (width_ext > CWW'(MAX_WIDTH))          img_width = WB'(MAX_WIDTH);
      else                                           img_width = WB'(width_ext);

      priority if (height_ext < CWH'(MIN_DIM))       img_height = HB'(MIN_DIM);
      else if (height_ext > CWH'(MAX_HEIGHT))        img_height = HB'(MAX_HEIGHT);
      else                                           img_height = HB'(height_ext);
   end

endmodule

// ===== hw/rtl/bbnr_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbnr_ctrl
// Raster position counters, per-item decisions and the first pipeline slot.
// ----------------------------------------------------------------------------
module bbnr_ctrl import bbnr_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   localparam int CB = $clog2(MAX_WIDTH),
   localparam int WB = $clog2(MAX_WIDTH + 1),
   localparam int HB = $clog2(MAX_HEIGHT + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [WB-1:0]       img_width,
   input  logic [HB-1:0]       img_height,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [PIX_BITS-1:0] req_tdata,
   input  logic                req_tuser,
   input  logic                b_free,
   output logic                a_adv,
   output slot_ctl_type        a_ctl,
   output logic [CB-1:0]       a_col,
   output logic                rd_en,
   output logic [CB-1:0]       rd_addr
);

   localparam int RB = $clog2(MAX_HEIGHT + 2);
   localparam int RC = RB + 1;

   logic [CB-1:0] col_ff, col_in;
   logic [RB-1:0] row_ff, row_in;
   logic          a_valid_ff, a_valid_in;
   slot_ctl_type  a_ctl_ff, a_ctl_in;
   logic [CB-1:0] a_col_ff, a_col_in;

   logic          accept, flush, drain, frame_end, ignore, load;
   logic [WB-1:0] col_inc;
   logic [RC-1:0] row_ext, h_ext;

   assign req_tready = ~a_valid_ff | b_free;
   assign accept     = req_tvalid & req_tready;
   assign a_adv      = a_valid_ff & b_free;

   assign col_inc   = WB'(col_ff) + WB'(1);
   assign row_ext   = RC'(row_ff);
   assign h_ext     = RC'(img_height);
   assign flush     = (req_tuser == KIND_FLUSH);
   assign drain     = row_ext >= h_ext;
   assign frame_end = row_ext > h_ext;
   // flush before the whole frame is in does nothing
   assign ignore    = flush & ~drain;
   assign load      = accept & ~ignore;

   assign rd_en   = load & ~frame_end;
   assign rd_addr = col_ff;

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      a_valid_in = a_valid_ff;
      a_ctl_in   = a_ctl_ff;
      a_col_in   = a_col_ff;

      if (a_adv) a_valid_in = 1'b0;

      if (load) begin
         a_valid_in           = 1'b1;
         a_col_in             = col_ff;
         a_ctl_in.final_item  = frame_end;
         a_ctl_in.drain       = drain;
         a_ctl_in.emit        = ~((row_ff == RB'(0)) ||
                                  ((row_ff == RB'(1)) && (col_ff == CB'(0))));
         a_ctl_in.interior    = (row_ext >= RC'(2)) && (row_ext + RC'(1) <= h_ext) &&
                                (col_ff >= CB'(2)) && (col_inc <= img_width);
         a_ctl_in.pixel       = drain ? '0 : req_tdata;

         if (frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (col_inc >= img_width) begin
            col_in = '0;
            row_in = row_ff + RB'(1);
         end else begin
            col_in = CB'(col_inc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         a_valid_ff <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ctl_ff <= a_ctl_in;
      a_col_ff <= a_col_in;
   end

   assign a_ctl = a_ctl_ff;
   assign a_col = a_col_ff;

endmodule

// ===== hw/rtl/bbnr_line_buf.sv =====
// ----------------------------------------------------------------------------
// bbnr_line_buf
// Two previous image rows in one memory word: {row two above, row above}.
// ----------------------------------------------------------------------------
module bbnr_line_buf import bbnr_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   localparam int CB = $clog2(MAX_WIDTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [CB-1:0]         wr_addr,
   input  logic [2*PIX_BITS-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [CB-1:0]         rd_addr,
   output logic [2*PIX_BITS-1:0] rd_data
);

   logic [2*PIX_BITS-1:0] mem [MAX_WIDTH];
   logic [2*PIX_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bbnr_window.sv =====
// ----------------------------------------------------------------------------
// bbnr_window
// 3x3 window shift, line buffer write-back and window sum.
// ----------------------------------------------------------------------------
module bbnr_window import bbnr_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   localparam int CB = $clog2(MAX_WIDTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  a_adv,
   input  slot_ctl_type          a_ctl,
   input  logic [CB-1:0]         a_col,
   input  logic [2*PIX_BITS-1:0] rd_data,
   output logic                  wr_en,
   output logic [CB-1:0]         wr_addr,
   output logic [2*PIX_BITS-1:0] wr_data,
   input  logic                  out_ready,
   output logic                  b_free,
   output logic                  b_valid,
   output win_res_type           b_res
);

   // rows top to bottom, columns oldest to newest
   logic [PIX_BITS-1:0] win_ff [9];
   logic [PIX_BITS-1:0] win_in [9];
   logic                b_valid_ff, b_valid_in;
   win_res_type         b_res_ff, b_res_in;

   logic [PIX_BITS-1:0] up2, up1;
   logic [SUM_BITS-1:0] sum;

   assign up2 = rd_data[2*PIX_BITS-1:PIX_BITS];
   assign up1 = rd_data[PIX_BITS-1:0];

   assign b_free = ~b_valid_ff | out_ready;

   assign wr_en   = a_adv & ~a_ctl.final_item & ~a_ctl.drain;
   assign wr_addr = a_col;
   assign wr_data = {up1, a_ctl.pixel};

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r*3 + 0] = win_ff[r*3 + 1];
         win_in[r*3 + 1] = win_ff[r*3 + 2];
      end
      win_in[2] = up2;
      win_in[5] = up1;
      win_in[8] = a_ctl.pixel;
   end

   always_comb begin
      sum = '0;
      for (int k = 0; k < 9; k++) sum = sum + SUM_BITS'(win_in[k]);
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      b_res_in   = b_res_ff;
      if (b_valid_ff && out_ready) b_valid_in = 1'b0;
      if (a_adv && (a_ctl.emit || a_ctl.final_item)) begin
         b_valid_in        = 1'b1;
         b_res_in.sum      = sum;
         // the pixel under the window center is the held middle-row pixel
         b_res_in.orig     = win_ff[5];
         b_res_in.interior = a_ctl.interior & ~a_ctl.final_item;
         b_res_in.last     = a_ctl.final_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) win_ff[k] <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_adv && !a_ctl.final_item) begin
            for (int k = 0; k < 9; k++) win_ff[k] <= win_in[k];
         end
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_res_ff <= b_res_in;
   end

   assign b_valid = b_valid_ff;
   assign b_res   = b_res_ff;

endmodule

// ===== hw/rtl/bbnr_out.sv =====
// ----------------------------------------------------------------------------
// bbnr_out
// Mean by reciprocal multiply, noise residual and the result register.
// ----------------------------------------------------------------------------
module bbnr_out import bbnr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  b_valid,
   input  win_res_type           b_res,
   output logic                  out_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [2*PIX_BITS-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic                  valid_ff, valid_in;
   logic [2*PIX_BITS-1:0] data_ff;
   logic                  last_ff;

   logic [PROD_BITS-1:0]  prod;
   logic [PIX_BITS-1:0]   mean, blur, noise;
   logic signed [PIX_BITS:0] diff;

   assign out_ready = ~valid_ff | rsp_tready;

   assign prod = PROD_BITS'(b_res.sum) * PROD_BITS'(MEAN_RECIP);
   assign mean = prod[RECIP_SHIFT +: PIX_BITS];
   assign blur = b_res.interior ? mean : b_res.orig;
   assign diff = $signed({1'b0, blur}) - $signed({1'b0, b_res.orig});

   always_comb begin
      if (diff < RESID_LIMIT) noise = diff[PIX_BITS-1:0] + RESID_OFFSET;
      else                    noise = diff[PIX_BITS-1:0];
   end

   always_comb begin
      valid_in = valid_ff;
      if (out_ready) valid_in = b_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (b_valid && out_ready) begin
         data_ff <= {noise, blur};
         last_ff <= b_res.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== dv/box_blur_noise_residual_tb.sv =====
// ----------------------------------------------------------------------------
// box_blur_noise_residual_tb
// Self-checking bench for the streaming 3x3 box mean with noise residual.
// A scoreboard class tracks the line buffers, the window and the raster
// position. From every input transaction it predicts the result, if any, and
// compares the result stream with that prediction. Frame sizes are set over
// the register port and read back. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module box_blur_noise_residual_tb;
   import bbnr_pkg::*;

   localparam int NBHD_SIZE = 9;

   // raster order, 4 wide and 3 high: one interior pixel on each side of 127
   localparam logic [PIX_BITS-1:0] TEST_GRID [12] = '{
      8'hFF, 8'hFF, 8'h00, 8'h00,
      8'hFF, 8'h00, 8'hFF, 8'h00,
      8'hFF, 8'hFF, 8'h00, 8'h00
   };

   typedef struct {
      logic [PIX_BITS-1:0] blurred;
      logic [PIX_BITS-1:0] noise;
      logic                last;
   } blur_out_type;

   class blur_residual_board_type;
      logic [WIDTH_REG_BITS-1:0]  width_csr;
      logic [HEIGHT_REG_BITS-1:0] height_csr;
      logic [PIX_BITS-1:0]        row_prev  [DEF_MAX_WIDTH];
      logic [PIX_BITS-1:0]        row_prev2 [DEF_MAX_WIDTH];
      logic [PIX_BITS-1:0]        nbhd      [NBHD_SIZE];
      int unsigned                col_pos;
      int unsigned                row_pos;
      blur_out_type               pending_pixels [$];
      int unsigned                errors;
      int unsigned                results_seen;

      function new();
         width_csr  = WIDTH_REG_BITS'(WIDTH_RESET);
         height_csr = HEIGHT_REG_BITS'(HEIGHT_RESET);
         foreach (row_prev[i]) begin
            row_prev[i]  = '0;
            row_prev2[i] = '0;
         end
         foreach (nbhd[i]) nbhd[i] = '0;
         col_pos      = 0;
         row_pos      = 0;
         errors       = 0;
         results_seen = 0;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("MISMATCH: %s", msg);
      endfunction

      static function int unsigned bound(int unsigned v, int unsigned hi);
         return (v < MIN_DIM) ? MIN_DIM : (v > hi) ? hi : v;
      endfunction

      function int unsigned frame_width();
         return bound(32'(width_csr), DEF_MAX_WIDTH);
      endfunction

      function int unsigned frame_height();
         return bound(32'(height_csr), DEF_MAX_HEIGHT);
      endfunction

      function void write_size(reg_idx_type idx, logic [CSR_DATA_BITS-1:0] word);
         if (idx == REG_IMAGE_WIDTH) width_csr = word[WIDTH_REG_BITS-1:0];
         else height_csr = word[HEIGHT_REG_BITS-1:0];
      endfunction

      static function logic [PIX_BITS-1:0] residual(logic [PIX_BITS-1:0] blur,
                                                    logic [PIX_BITS-1:0] orig);
         int d;
         d = int'(blur) - int'(orig);
         if (d < int'(RESID_LIMIT)) d += int'(RESID_OFFSET);
         return d[PIX_BITS-1:0];
      endfunction

      // Advance the raster state by one accepted transaction and queue the
      // result it produces.
      function void note_input(kind_type kind, logic [PIX_BITS-1:0] pixel);
         int unsigned w, h, col, sum;
         logic [PIX_BITS-1:0] held, px, orig, blur;
         bit draining, emit, interior;
         blur_out_type res;
         w = frame_width();
         h = frame_height();
         draining = row_pos >= h;
         held = nbhd[5];
         // flush before the frame is complete: no effect at all
         if (kind == KIND_FLUSH && !draining) return;
         if (row_pos >= h + 1) begin
            res = '{held, RESID_OFFSET, 1'b1};
            pending_pixels.push_back(res);
            col_pos = 0;
            row_pos = 0;
            return;
         end
         col = (col_pos >= DEF_MAX_WIDTH) ? DEF_MAX_WIDTH - 1 : col_pos;
         // any item during the drain rows counts as a flush
         px = draining ? '0 : pixel;
         for (int r = 0; r < 3; r++) begin
            nbhd[3*r]   = nbhd[3*r+1];
            nbhd[3*r+1] = nbhd[3*r+2];
         end
         nbhd[2] = row_prev2[col];
         nbhd[5] = row_prev[col];
         nbhd[8] = px;
         if (!draining) begin
            row_prev2[col] = row_prev[col];
            row_prev[col]  = px;
         end
         emit = !(row_pos == 0 || (row_pos == 1 && col == 0));
         orig = '0;
         blur = '0;
         if (emit) begin
            if (col == 0) begin
               // last column of the previous row, always a border pixel
               orig = held;
               blur = held;
            end else begin
               orig = nbhd[4];
               interior = row_pos >= 2 && row_pos + 1 <= h && col >= 2 && col + 1 <= w;
               if (interior) begin
                  sum = 0;
                  foreach (nbhd[k]) sum += 32'(nbhd[k]);
                  blur = PIX_BITS'(sum / NBHD_SIZE);
               end else begin
                  blur = orig;
               end
            end
         end
         if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos++;
         end else begin
            col_pos++;
         end
         if (emit) begin
            res = '{blur, residual(blur, orig), 1'b0};
            pending_pixels.push_back(res);
         end
      endfunction

      function void check_result(logic [PIX_BITS-1:0] blurred, logic [PIX_BITS-1:0] noise,
                                 logic last);
         blur_out_type want;
         results_seen++;
         if (pending_pixels.size() == 0) begin
            flag($sformatf("result %0d with none outstanding: blurred %0d noise %0d last %0b",
                           results_seen, blurred, noise, last));
            return;
         end
         want = pending_pixels.pop_front();
         if (blurred !== want.blurred)
            flag($sformatf("result %0d blurred: expected %0d, got %0d",
                           results_seen, want.blurred, blurred));
         if (noise !== want.noise)
            flag($sformatf("result %0d noise: expected %0d, got %0d",
                           results_seen, want.noise, noise));
         if (last !== want.last)
            flag($sformatf("result %0d frame_last: expected %0b, got %0b",
                           results_seen, want.last, last));
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [PIX_BITS-1:0]      req_tdata = '0;
   logic                     req_tuser = KIND_PIXEL;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [2*PIX_BITS-1:0]    rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   blur_residual_board_type sb = new();
   bit                      steady = 1'b0;
   int unsigned             ready_hold = 0;
   int unsigned             random_items = 0;

   box_blur_noise_residual dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [PIX_BITS-1:0] pick_pixel();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return PIX_BITS'($urandom_range(255));
      endcase
   endfunction

   // result side: hold off for a random stretch after each ready cycle
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         ready_hold <= pick_gap();
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[PIX_BITS-1:0], rsp_tdata[2*PIX_BITS-1:PIX_BITS], rsp_tlast);
   end

   task automatic send_item(kind_type kind, logic [PIX_BITS-1:0] pixel);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pixel;
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      sb.note_input(kind, pixel);
   endtask

   // Write both size registers in turn, reading each one back after its write.
   task automatic program_size(logic [CSR_DATA_BITS-1:0] width_word,
                               logic [CSR_DATA_BITS-1:0] height_word);
      logic [CSR_DATA_BITS-1:0] word;
      logic [CSR_DATA_BITS-1:0] want;
      reg_idx_type idx;
      for (int i = 0; i < 2; i++) begin
         idx  = reg_idx_type'(i);
         word = (idx == REG_IMAGE_WIDTH) ? width_word : height_word;
         want = (idx == REG_IMAGE_WIDTH) ? CSR_DATA_BITS'(word[WIDTH_REG_BITS-1:0])
                                         : CSR_DATA_BITS'(word[HEIGHT_REG_BITS-1:0]);
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= CSR_ADDR_BITS'(4 * int'(idx));
         csr_pwdata  <= word;
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         sb.write_size(idx, word);
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b0;
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         if (csr_prdata !== want)
            sb.flag($sformatf("%s reads back %0d, expected %0d", idx.name(), csr_prdata, want));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // One full frame at the current size, with stray flushes in the pixel
   // phase and some pixels mixed into the drain.
   task automatic run_frame();
      int unsigned w, h;
      w = sb.frame_width();
      h = sb.frame_height();
      for (int unsigned n = 0; n < w * h; n++) begin
         if ($urandom_range(19) == 0) send_item(KIND_FLUSH, pick_pixel());
         send_item(KIND_PIXEL, pick_pixel());
      end
      for (int unsigned n = 0; n <= w; n++)
         send_item(($urandom_range(4) == 0) ? KIND_PIXEL : KIND_FLUSH, pick_pixel());
      random_items += w * h + w + 1;
   endtask

   // Drop valid, drain every outstanding result, then let the pipe empty.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      int unsigned w, h;
      logic [CSR_DATA_BITS-1:0] width_word, height_word;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      program_size(32'd4, 32'd3);
      send_item(KIND_FLUSH, 8'hFF);
      foreach (TEST_GRID[i]) begin
         if (i == 6) send_item(KIND_FLUSH, 8'h00);
         send_item(KIND_PIXEL, TEST_GRID[i]);
      end
      for (int i = 0; i < 5; i++)
         send_item((i == 2) ? KIND_PIXEL : KIND_FLUSH, 8'hA5);
      settle();

      while (random_items < 550) begin
         steady = ($urandom_range(4) == 0);
         case ($urandom_range(9))
            0:       w = $urandom_range(2);
            1:       w = $urandom_range(40, 10);
            default: w = $urandom_range(9, 3);
         endcase
         h = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(7, 3);
         width_word  = CSR_DATA_BITS'(w);
         height_word = CSR_DATA_BITS'(h);
         if ($urandom_range(3) == 0)
            width_word[CSR_DATA_BITS-1:WIDTH_REG_BITS] =
               (CSR_DATA_BITS-WIDTH_REG_BITS)'($urandom);
         if ($urandom_range(3) == 0)
            height_word[CSR_DATA_BITS-1:HEIGHT_REG_BITS] =
               (CSR_DATA_BITS-HEIGHT_REG_BITS)'($urandom);
         program_size(width_word, height_word);
         run_frame();
         settle();
      end

      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
